[src/assert_macros.svh]
// Assertion macros shared by the converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while out of reset.
`define PSFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/psfc_pkg.sv]
// Types and constants of the PCM sample format converter.
package psfc_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = QPtrW + 1;
  localparam int PaddrW = 3;

  localparam logic RegSrc = 1'b0;
  localparam logic RegDst = 1'b1;

  typedef enum logic [2:0] {
    SRC_U8  = 3'd0,
    SRC_I16 = 3'd1,
    SRC_I24 = 3'd2,
    SRC_I32 = 3'd3,
    SRC_F32 = 3'd4,
    SRC_F64 = 3'd5
  } src_fmt_e;

  typedef enum logic [2:0] {
    DST_I16  = 3'd0,
    DST_I24  = 3'd1,
    DST_I32  = 3'd2,
    DST_F32  = 3'd3,
    DST_F64  = 3'd4,
    DST_I16W = 3'd5,
    DST_I24W = 3'd6
  } dst_fmt_e;

  // Sample class after decode.
  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_UNNORM = 3'd1,  // magnitude in mant[31:0], value = mag * 2^exp
    CLS_NORM   = 3'd2,  // leading one at mant[63], value = mant * 2^(exp-63)
    CLS_F64SUB = 3'd3,  // float64 subnormal, fraction in mant[51:0]
    CLS_INF    = 3'd4,
    CLS_NAN    = 3'd5
  } cls_e;

  typedef struct packed {
    logic [4:0]  channel;
    logic [11:0] position;
    logic [63:0] sample_in;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  channel_out;
    logic [14:0] byte_offset;
    logic [63:0] sample_out;
    logic [3:0]  byte_count;
  } out_req_t;

  typedef struct packed {
    logic [4:0]         channel;
    logic [14:0]        byte_offset;
    logic [3:0]         byte_count;
    logic [2:0]         dst;
    cls_e               cls;
    logic               sign;
    logic signed [12:0] exp;
    logic [63:0]        mant;
  } item_t;

  localparam logic signed [12:0] ExpZero = -13'sd2048;
  localparam logic signed [12:0] ExpInf  = 13'sd2047;

endpackage

[src/psfc_front.sv]
// Front end: decodes a raw sample into a class, sign, exponent and mantissa.
module psfc_front import psfc_pkg::*; (
  input  in_req_t    req_i,
  input  logic [2:0] src_fmt_i,
  input  logic [2:0] dst_fmt_i,
  output item_t      item_o
);

  logic signed [32:0] ival;
  logic               is_int;
  logic signed [12:0] ebase;
  logic [32:0]        mag;
  logic [7:0]         e8;
  logic [10:0]        e11;
  logic [3:0]         nbytes;
  logic [14:0]        pos15;

  always_comb begin
    ival   = '0;
    is_int = 1'b1;
    ebase  = -13'sd15;
    e8     = req_i.sample_in[30:23];
    e11    = req_i.sample_in[62:52];
    item_o = '0;
    item_o.cls = CLS_ZERO;
    item_o.exp = ExpZero;

    case (src_fmt_e'(src_fmt_i))
      SRC_U8: begin
        ival  = $signed({25'b0, req_i.sample_in[7:0]}) - 33'sd128;
        ebase = -13'sd7;
      end
      SRC_I16: begin
        ival  = {{17{req_i.sample_in[15]}}, req_i.sample_in[15:0]};
        ebase = -13'sd15;
      end
      SRC_I24: begin
        ival  = {{9{req_i.sample_in[23]}}, req_i.sample_in[23:0]};
        ebase = -13'sd23;
      end
      SRC_I32: begin
        ival  = {req_i.sample_in[31], req_i.sample_in[31:0]};
        ebase = -13'sd31;
      end
      SRC_F32: begin
        is_int      = 1'b0;
        item_o.sign = req_i.sample_in[31];
        if (e8 == 8'hff) begin
          item_o.cls  = (req_i.sample_in[22:0] != '0) ? CLS_NAN : CLS_INF;
          item_o.exp  = ExpInf;
          item_o.mant = {1'b1, 63'b0};
        end else if (e8 == 8'h00) begin
          if (req_i.sample_in[22:0] != '0) begin
            item_o.cls  = CLS_UNNORM;
            item_o.exp  = -13'sd149;
            item_o.mant = {41'b0, req_i.sample_in[22:0]};
          end
        end else begin
          item_o.cls  = CLS_NORM;
          item_o.exp  = $signed({5'b0, e8}) - 13'sd127;
          item_o.mant = {1'b1, req_i.sample_in[22:0], 40'b0};
        end
      end
      SRC_F64: begin
        is_int      = 1'b0;
        item_o.sign = req_i.sample_in[63];
        if (e11 == 11'h7ff) begin
          item_o.cls  = (req_i.sample_in[51:0] != '0) ? CLS_NAN : CLS_INF;
          item_o.exp  = ExpInf;
          item_o.mant = {1'b1, 63'b0};
        end else if (e11 == 11'h000) begin
          if (req_i.sample_in[51:0] != '0) begin
            item_o.cls  = CLS_F64SUB;
            item_o.mant = {12'b0, req_i.sample_in[51:0]};
          end
        end else begin
          item_o.cls  = CLS_NORM;
          item_o.exp  = $signed({2'b0, e11}) - 13'sd1023;
          item_o.mant = {1'b1, req_i.sample_in[51:0], 11'b0};
        end
      end
      default: ;  // unused codes decode as integer zero
    endcase

    // integer samples: sign and magnitude, value = mag * 2^-(w-1)
    mag = ival[32] ? 33'(-ival) : 33'(ival);
    if (is_int && ival != '0) begin
      item_o.cls  = CLS_UNNORM;
      item_o.sign = ival[32];
      item_o.exp  = ebase;
      item_o.mant = {32'b0, mag[31:0]};
    end

    case (dst_fmt_e'(dst_fmt_i))
      DST_I16: nbytes = 4'd2;
      DST_I24: nbytes = 4'd3;
      DST_F64: nbytes = 4'd8;
      default: nbytes = 4'd4;
    endcase

    pos15 = {3'b0, req_i.position};
    case (nbytes)
      4'd2:    item_o.byte_offset = pos15 << 1;
      4'd3:    item_o.byte_offset = (pos15 << 1) + pos15;
      4'd8:    item_o.byte_offset = pos15 << 3;
      default: item_o.byte_offset = pos15 << 2;
    endcase

    item_o.channel    = req_i.channel;
    item_o.byte_count = nbytes;
    item_o.dst        = dst_fmt_i;
  end

endmodule

[src/psfc_fifo.sv]
// Short queue between the decode front end and the conversion back end.
`include "assert_macros.svh"
module psfc_fifo import psfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t rdata_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `PSFC_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `PSFC_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from empty queue")
  `PSFC_ASSERT(a_cnt_tracks, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

[src/psfc_back.sv]
// Back end: normalize, rounding shift, then saturate and pack the result.
`include "assert_macros.svh"
module psfc_back import psfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  item_t    q_item_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  typedef struct packed {
    logic [4:0]         channel;
    logic [14:0]        byte_offset;
    logic [3:0]         byte_count;
    logic [2:0]         dst;
    cls_e               cls;
    logic               sign;
    logic signed [12:0] exp;
    logic [63:0]        mant;
    logic [32:0]        q;
    logic               guard;
    logic               sticky;
    logic               big;
    logic               sat;
    logic [7:0]         e8;
  } shf_t;

  logic     v1_q, v2_q, v3_q;
  logic     adv1, adv2, adv3;
  item_t    s1_q, s1_d;
  shf_t     s2_q, s2_d;
  out_req_t s3_q, s3_d;

  assign adv3        = !v3_q || !out_stall_i;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign q_pop_o     = q_valid_i && adv1;
  assign out_valid_o = v3_q;
  assign out_req_o   = s3_q;

  // Stage 1: leading-zero normalize of integer and small float magnitudes.
  logic [31:0] nm;
  logic [4:0]  lz;
  always_comb begin
    s1_d = q_item_i;
    nm   = q_item_i.mant[31:0];
    lz   = '0;
    if (nm[31:16] == '0) begin nm = nm << 16; lz[4] = 1'b1; end
    if (nm[31:24] == '0) begin nm = nm << 8;  lz[3] = 1'b1; end
    if (nm[31:28] == '0) begin nm = nm << 4;  lz[2] = 1'b1; end
    if (nm[31:30] == '0) begin nm = nm << 2;  lz[1] = 1'b1; end
    if (nm[31] == 1'b0)  begin nm = nm << 1;  lz[0] = 1'b1; end
    if (q_item_i.cls == CLS_UNNORM) begin
      s1_d.cls  = CLS_NORM;
      s1_d.mant = {nm, 32'b0};
      s1_d.exp  = q_item_i.exp + 13'sd31 - $signed({8'b0, lz});
    end
  end

  // Stage 2: shift amount per destination, shift with guard and sticky.
  logic signed [13:0] sh_s;
  logic [6:0]         sh;
  logic [127:0]       ext;
  logic               is_norm;
  always_comb begin
    is_norm = (s1_q.cls == CLS_NORM);
    case (dst_fmt_e'(s1_q.dst))
      DST_I16, DST_I16W: sh_s = 14'sd48 - {s1_q.exp[12], s1_q.exp};
      DST_I24, DST_I24W: sh_s = 14'sd40 - {s1_q.exp[12], s1_q.exp};
      DST_I32:           sh_s = 14'sd32 - {s1_q.exp[12], s1_q.exp};
      default: begin
        // float32: fixed point of the normal range, else subnormal scale
        if (s1_q.exp >= -13'sd126) begin
          sh_s = 14'sd40;
        end else begin
          sh_s = -14'sd86 - {s1_q.exp[12], s1_q.exp};
        end
      end
    endcase
    if (sh_s < 14'sd0) begin
      sh = '0;
    end else if (sh_s > 14'sd65) begin
      sh = 7'd65;
    end else begin
      sh = sh_s[6:0];
    end
    ext = {s1_q.mant, 64'b0} >> sh;

    s2_d.channel     = s1_q.channel;
    s2_d.byte_offset = s1_q.byte_offset;
    s2_d.byte_count  = s1_q.byte_count;
    s2_d.dst         = s1_q.dst;
    s2_d.cls         = s1_q.cls;
    s2_d.sign        = s1_q.sign;
    s2_d.exp         = s1_q.exp;
    s2_d.mant        = s1_q.mant;
    s2_d.q           = ext[96:64];
    s2_d.guard       = ext[63];
    s2_d.sticky      = (ext[62:0] != '0);
    // magnitude above 1.0
    s2_d.big = (s1_q.cls == CLS_INF) ||
               (is_norm && (s1_q.exp > 13'sd0 ||
                            (s1_q.exp == 13'sd0 && s1_q.mant[62:0] != '0)));
    // magnitude at or above full scale for integers
    s2_d.sat = (s1_q.cls == CLS_INF) || (is_norm && s1_q.exp >= 13'sd0);
    s2_d.e8  = (s1_q.exp >= -13'sd126) ? 8'(s1_q.exp + 13'sd126) : 8'd0;
  end

  // Stage 3: round to nearest even, saturate, pack.
  logic [32:0] r, half, ires;
  logic [30:0] f32mag;
  always_comb begin
    r = s2_q.q + {32'b0, s2_q.guard && (s2_q.sticky || s2_q.q[0])};
    case (dst_fmt_e'(s2_q.dst))
      DST_I16, DST_I16W: half = 33'h0_0000_8000;
      DST_I24, DST_I24W: half = 33'h0_0080_0000;
      default:           half = 33'h0_8000_0000;
    endcase
    if (s2_q.cls == CLS_NAN) begin
      ires = '0;
    end else if (s2_q.sat || r >= half) begin
      ires = s2_q.sign ? (~half + 33'd1) : (half - 33'd1);
    end else begin
      ires = s2_q.sign ? (~r + 33'd1) : r;
    end
    f32mag = {s2_q.e8, 23'b0} + {6'b0, r[24:0]};

    s3_d.channel_out = s2_q.channel;
    s3_d.byte_offset = s2_q.byte_offset;
    s3_d.byte_count  = s2_q.byte_count;
    case (dst_fmt_e'(s2_q.dst))
      DST_I16: s3_d.sample_out = {48'b0, ires[15:0]};
      DST_I24: s3_d.sample_out = {40'b0, ires[23:0]};
      DST_I32, DST_I16W, DST_I24W: s3_d.sample_out = {32'b0, ires[31:0]};
      DST_F32: begin
        if (s2_q.cls == CLS_NAN) begin
          s3_d.sample_out = 64'h0000_0000_7fc0_0000;
        end else if (s2_q.big) begin
          s3_d.sample_out = {32'b0, s2_q.sign, 31'h3f80_0000};
        end else if (s2_q.cls == CLS_NORM) begin
          s3_d.sample_out = {32'b0, s2_q.sign, f32mag};
        end else begin
          s3_d.sample_out = {32'b0, s2_q.sign, 31'b0};
        end
      end
      DST_F64: begin
        if (s2_q.cls == CLS_NAN) begin
          s3_d.sample_out = 64'h7ff8_0000_0000_0000;
        end else if (s2_q.big) begin
          s3_d.sample_out = {s2_q.sign, 63'h3ff0_0000_0000_0000};
        end else if (s2_q.cls == CLS_NORM) begin
          s3_d.sample_out = {s2_q.sign, 11'(s2_q.exp + 13'sd1023), s2_q.mant[62:11]};
        end else if (s2_q.cls == CLS_F64SUB) begin
          s3_d.sample_out = {s2_q.sign, 11'b0, s2_q.mant[51:0]};
        end else begin
          s3_d.sample_out = {s2_q.sign, 63'b0};
        end
      end
      default: s3_d.sample_out = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= q_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
  end

  `PSFC_ASSERT(a_s1_held, (v1_q && !adv2) |=> v1_q, "stage 1 request dropped")
  `PSFC_ASSERT(a_s2_held, (v2_q && !adv3) |=> v2_q && $stable(s2_q), "stage 2 request lost")
  `PSFC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

[src/pcm_sample_format_converter_core.sv]
// Top level of the PCM sample format converter: config registers and pipeline.
// An accepted request enters the queue, then the stage 1, 2 and 3 registers.
// Throughput: one request per cycle when not stalled; combinational decode front
// end, three-stage back end (normalize, rounding shift, saturate/pack).
// A 4-entry queue decouples the two halves, so either side can stall alone.
// Reset: rst_ni async low; empties the pipeline, source format int16, dest int16.
module pcm_sample_format_converter_core import psfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input requests
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  // results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_req_t          out_req_o,
  // APB config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [2:0] src_q, dst_q;
  logic       cfg_wr;
  logic       q_full, q_valid, q_pop, q_push;
  item_t      f_item, q_item;

  // Config regs: index = paddr[2], value masked to 3 bits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegDst) ? {29'b0, dst_q} : {29'b0, src_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SRC_I16;
      dst_q <= DST_I16;
    end else if (cfg_wr) begin
      if (paddr[2] == RegSrc) begin
        src_q <= pwdata[2:0];
      end else begin
        dst_q <= pwdata[2:0];
      end
    end
  end

  // Front: classify; request goes straight into the queue.
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  psfc_front u_front (
    .req_i     (in_req_i),
    .src_fmt_i (src_q),
    .dst_fmt_i (dst_q),
    .item_o    (f_item)
  );

  psfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  psfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

[tb/sv/tb_top.sv]
// Testbench for the PCM sample format converter: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
  import psfc_pkg::*;

  localparam int StallLimit = 3000;  // cycles with no handshake before giving up

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_req_t          out_req_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  pcm_sample_format_converter_core u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the format registers, kept in step with every APB write.
  logic [2:0] src_fmt;
  logic [2:0] dst_fmt;

  out_req_t   pending_q[$];  // converted samples still owed by the block
  int         fail_count = 0;
  int         gap_pct = 29;   // idle percentage on both sides
  bit         hold_out = 1'b0;

  // ---------------------------------------------------------------------------
  // Conversion predictor
  // ---------------------------------------------------------------------------

  function automatic real pow2(int k);
    real p;
    p = 1.0;
    repeat (k < 0 ? -k : k) p = (k < 0) ? p / 2.0 : p * 2.0;
    return p;
  endfunction

  function automatic real f32_bits_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hff)
      return $bitstoreal(b[22:0] != 0 ? 64'h7ff8000000000000 : {b[31], 63'h7ff0000000000000});
    if (b[30:23] == 8'h00) begin
      r = b[22:0];
      r = r * pow2(-149);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
  endfunction

  // Double to single, round to nearest even, subnormals included.
  // Called on values within [-1.25, 1.25]: clamped results and random stimulus.
  function automatic logic [31:0] real_to_f32_bits(real x);
    logic [63:0] b;
    int          ee;
    int          sh;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    b = $realtobits(x);
    if (b[62:52] == 11'd0) return {b[63], 31'b0};
    ee = int'(b[62:52]) - 1023 + 127;
    m  = {11'b0, 1'b1, b[51:0]};
    sh = (ee >= 1) ? 29 : 30 - ee;
    if (sh > 60) return {b[63], 31'b0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (ee >= 1) q = {33'b0, 8'(ee), q[22:0]};
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return {b[63], q[30:0]};
  endfunction

  function automatic longint real_trunc(real x);
    return (x >= 0.0) ? longint'($floor(x)) : longint'($ceil(x));
  endfunction

  // Scale to an n-bit signed integer, round to nearest even, saturate.
  function automatic longint scale_to_int(bit is_int, int w, longint iv, real fv, bit nan,
                                          int n);
    longint hi;
    longint lo;
    longint q;
    longint rem;
    longint half;
    real    x;
    real    fr;
    hi = (64'sd1 <<< (n - 1)) - 1;
    lo = -hi - 1;
    if (is_int) begin
      if (w <= n) return iv <<< (n - w);
      q    = iv >>> (w - n);
      rem  = iv - (q <<< (w - n));
      half = 64'sd1 <<< (w - n - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return (q > hi) ? hi : q;
    end
    if (nan) return 0;
    x = fv * pow2(n - 1);
    if (x >= real'(hi)) return hi;
    if (x <= real'(lo)) return lo;
    q  = real_trunc(x);
    fr = x - real'(q);
    if (fr > 0.5) q++;
    else if (fr < -0.5) q--;
    else if (fr == 0.5 && q[0]) q++;
    else if (fr == -0.5 && q[0]) q--;
    return q;
  endfunction

  function automatic out_req_t convert_sample(in_req_t r);
    out_req_t    o;
    bit          is_int;
    bit          nan;
    int          w;
    longint      iv;
    real         fv;
    real         u;
    longint      t;
    logic [63:0] res;
    logic [3:0]  nbytes;
    is_int = 1'b1;
    nan    = 1'b0;
    w      = 16;
    iv     = 0;
    fv     = 0.0;
    res    = '0;
    nbytes = 4'd4;
    case (src_fmt)
      SRC_U8:  begin w = 8;  iv = longint'(r.sample_in[7:0]) - 128; end
      SRC_I16: begin w = 16; iv = $signed(r.sample_in[15:0]); end
      SRC_I24: begin w = 24; iv = $signed(r.sample_in[23:0]); end
      SRC_I32: begin w = 32; iv = $signed(r.sample_in[31:0]); end
      SRC_F32: begin
        is_int = 1'b0;
        nan    = r.sample_in[30:23] == 8'hff && r.sample_in[22:0] != 0;
        fv     = f32_bits_to_real(r.sample_in[31:0]);
      end
      SRC_F64: begin
        is_int = 1'b0;
        nan    = r.sample_in[62:52] == 11'h7ff && r.sample_in[51:0] != 0;
        fv     = $bitstoreal(r.sample_in);
      end
      default: ;  // unused codes read as an integer zero
    endcase
    u = is_int ? real'(iv) / pow2(w - 1) : fv;
    if (!nan) begin
      if (u > 1.0) u = 1.0;
      else if (u < -1.0) u = -1.0;
    end
    case (dst_fmt)
      DST_I16: begin
        nbytes = 4'd2;
        t = scale_to_int(is_int, w, iv, fv, nan, 16);
        res = {48'b0, t[15:0]};
      end
      DST_I24: begin
        nbytes = 4'd3;
        t = scale_to_int(is_int, w, iv, fv, nan, 24);
        res = {40'b0, t[23:0]};
      end
      DST_I32: begin
        t = scale_to_int(is_int, w, iv, fv, nan, 32);
        res = {32'b0, t[31:0]};
      end
      DST_F32: res = nan ? 64'h7fc00000 : {32'b0, real_to_f32_bits(u)};
      DST_F64: begin
        nbytes = 4'd8;
        res = nan ? 64'h7ff8000000000000 : $realtobits(u);
      end
      DST_I16W: begin
        t = scale_to_int(is_int, w, iv, fv, nan, 16);
        res = {32'b0, t[31:0]};
      end
      DST_I24W: begin
        t = scale_to_int(is_int, w, iv, fv, nan, 24);
        res = {32'b0, t[31:0]};
      end
      default: res = '0;  // unused code: zero, four bytes
    endcase
    o.channel_out = r.channel;
    o.byte_offset = 15'(27'(r.position) * 27'(nbytes));
    o.sample_out  = res;
    o.byte_count  = nbytes;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake sampling: values are taken at the falling edge, settled, and
  // used at the next rising edge, where the handshake actually happens.
  // ---------------------------------------------------------------------------

  bit       in_fire_s;
  bit       out_fire_s;
  out_req_t out_seen_s;
  int       quiet_cycles = 0;

  always @(negedge clk_i) begin
    in_fire_s  = in_valid_i && !in_stall_o;
    out_fire_s = out_valid_o && !out_stall_i;
    out_seen_s = out_req_o;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (src %0d dst %0d)", what, got, want,
             src_fmt, dst_fmt);
    fail_count++;
  endtask

  // Result checker: every accepted result is matched to the oldest request.
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_fire_s) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", out_seen_s.sample_out, '0);
      end else begin
        want = pending_q.pop_front();
        if (out_seen_s.channel_out != want.channel_out)
          report_mismatch("channel_out", out_seen_s.channel_out, want.channel_out);
        if (out_seen_s.byte_offset != want.byte_offset)
          report_mismatch("byte_offset", out_seen_s.byte_offset, want.byte_offset);
        if (out_seen_s.sample_out != want.sample_out)
          report_mismatch("sample_out", out_seen_s.sample_out, want.sample_out);
        if (out_seen_s.byte_count != want.byte_count)
          report_mismatch("byte_count", out_seen_s.byte_count, want.byte_count);
      end
    end
  end

  // Receiver: random stalls, or a solid hold-off when the pressure test asks.
  always @(posedge clk_i) begin
    out_stall_i <= hold_out || ($urandom_range(99) < gap_pct);
  end

  // Watchdog on handshakes, not on total time.
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire_s || out_fire_s) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Sends one request; returns at the edge where it was taken, valid still high.
  task automatic send_sample(logic [4:0] chan, logic [11:0] pos, logic [63:0] raw);
    in_req_t r;
    r.channel   = chan;
    r.position  = pos;
    r.sample_in = raw;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    pending_q.push_back(convert_sample(r));
  endtask

  // Drain everything, then give the pipeline a few spare cycles.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // APB write: setup then access; junk in the upper data bits is ignored.
  task automatic write_format(logic reg_sel, logic [2:0] code);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {29'($urandom), code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == RegSrc) src_fmt = code;
    else dst_fmt = code;
  endtask

  task automatic set_formats(logic [2:0] s, logic [2:0] d);
    write_format(RegSrc, s);
    write_format(RegDst, d);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Raw sample shaped for the current source format: floats get mostly in-range
  // values, some specials and plain random bits; integers mostly random bits.
  function automatic logic [63:0] pick_sample();
    int  sel;
    real v;
    sel = $urandom_range(99);
    v   = (real'($urandom_range(4000000)) - 2000000.0) / 1600000.0;
    if (src_fmt == SRC_F32) begin
      if (sel < 55) return {$urandom, real_to_f32_bits(v)};
      if (sel < 75) return rand64();
      case ($urandom_range(5))
        0: return {$urandom, 32'h7f800000 | 32'($urandom_range(1))};
        1: return {$urandom, 32'hff800000};
        2: return {$urandom, 32'h80000000};
        3: return {$urandom, 32'h000000ff & $urandom};
        4: return {$urandom, 32'h37800000 | (32'($urandom_range(7)) << 23)};
        default: return {$urandom, 32'h3f800000};
      endcase
    end
    if (src_fmt == SRC_F64) begin
      if (sel < 55) return $realtobits(v);
      if (sel < 75) return rand64();
      case ($urandom_range(5))
        0: return 64'h7ff0000000000000 | 64'($urandom_range(1));
        1: return 64'hfff0000000000000;
        2: return 64'h8000000000000000;
        3: return 64'h0000000000000001 << $urandom_range(51);
        4: return 64'h36a0000000000000 + 64'($urandom_range(3));
        default: return 64'hbff0000000000000;
      endcase
    end
    if (sel < 80) return rand64();
    // integer extremes and rounding ties
    case ($urandom_range(3))
      0: return {$urandom, 32'h7fffffff};
      1: return {$urandom, 32'h80000000};
      2: return {$urandom, 16'($urandom), 16'h8000};
      default: return {$urandom, 24'($urandom), 8'h80};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset formats: int16 in, int16 out.
  task automatic test_reset_formats();
    send_sample(5'd0, 12'd0, 64'h0000_0000_0000_7fff);
    send_sample(5'd31, 12'd4095, 64'hffff_ffff_ffff_8000);
    send_sample(5'd1, 12'd1, 64'h1234_5678_9abc_0000);
  endtask

  // Float edges into int16: saturation, NaN, negative infinity, ties, subnormal.
  task automatic test_float_to_int();
    set_formats(SRC_F32, DST_I16);
    send_sample(5'd2, 12'd10, 64'h3f800000);      // +1.0 saturates
    send_sample(5'd3, 12'd11, 64'hbf800000);      // -1.0
    send_sample(5'd4, 12'd12, 64'h7fc00001);      // NaN -> 0
    send_sample(5'd5, 12'd13, 64'hff800000);      // -inf
    send_sample(5'd6, 12'd14, 64'h37800000);      // exactly half an lsb, even
    send_sample(5'd7, 12'd15, 64'h38400000);      // one and a half lsb
    send_sample(5'd8, 12'd16, 64'hffff_ffff_00000001);
  endtask

  // float64 into float32: NaN, negative zero, clamp, underflow.
  task automatic test_float_narrowing();
    set_formats(SRC_F64, DST_F32);
    send_sample(5'd9, 12'd20, 64'h7ff0000000000001);
    send_sample(5'd10, 12'd21, 64'h8000000000000000);
    send_sample(5'd11, 12'd22, 64'h4000000000000000);
    send_sample(5'd12, 12'd23, 64'h0000000000000001);
    send_sample(5'd13, 12'd24, 64'h36a0000000000000);
    send_sample(5'd14, 12'd25, 64'h7ff0000000000000);
  endtask

  // Offset u8 and integer narrowing ties, plus the unused codes.
  task automatic test_integer_paths();
    set_formats(SRC_U8, DST_F64);
    send_sample(5'd15, 12'd30, 64'hffff_ffff_ffff_ff00);
    send_sample(5'd16, 12'd4095, 64'h0000_0000_0000_00ff);
    set_formats(SRC_I32, DST_I16);
    send_sample(5'd17, 12'd31, 64'h0000_0000_7fff_ffff);
    send_sample(5'd18, 12'd32, 64'h0000_0000_0000_8000);
    send_sample(5'd19, 12'd33, 64'h0000_0000_0001_8000);
    set_formats(3'd6, 3'd7);
    send_sample(5'd20, 12'd34, rand64());
    set_formats(3'd7, DST_I24W);
    send_sample(5'd21, 12'd35, rand64());
  endtask

  // Random phases: new formats each phase, random content.
  task automatic test_random_streams();
    logic [2:0] s;
    logic [2:0] d;
    for (int ph = 0; ph < 40; ph++) begin
      s = 3'($urandom_range(7));
      d = 3'($urandom_range(7));
      if (ph == 0) begin s = SRC_U8; d = DST_I16; end
      if (ph == 1) begin s = SRC_F64; d = DST_I24W; end
      if (ph == 2) begin s = 3'd7; d = 3'd7; end
      set_formats(s, d);
      gap_pct = (ph >= 12 && ph < 18) ? 0 : 29;
      repeat (28) send_sample(5'($urandom), 12'($urandom), pick_sample());
    end
    gap_pct = 29;
  endtask

  // The receiver holds off long enough for the block to fill and stall.
  task automatic test_backpressure();
    set_formats(SRC_I24, DST_I32);
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join_none
    repeat (40) send_sample(5'($urandom), 12'($urandom), pick_sample());
  endtask

  initial begin
    // driven after time zero so the falling reset edge is seen by the block
    rst_ni  <= 1'b0;
    src_fmt = SRC_I16;
    dst_fmt = DST_I16;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_formats();
    test_float_to_int();
    test_float_narrowing();
    test_integer_paths();
    test_random_streams();
    test_backpressure();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[pcm_sample_format_converter_core.f]
+incdir+src
src/psfc_pkg.sv
src/psfc_front.sv
src/psfc_fifo.sv
src/psfc_back.sv
src/pcm_sample_format_converter_core.sv
tb/sv/tb_top.sv
